FILE: hdl/kbpc_pkg.sv
// Types, constants and round functions of the keyed bit permutation cipher.
// Used by keyed_bit_permutation_cipher_unit; depends on nothing else.
package kbpc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned NumWords = 4;
  localparam int unsigned NumKeys  = 4;
  localparam int unsigned KeyIdxW  = $clog2(NumKeys);
  localparam int unsigned NumStages = 4;
  localparam int unsigned RotW     = $clog2(WordW);

  typedef logic [WordW-1:0]               word_t;
  typedef logic [ByteW-1:0]               byte_t;
  typedef logic [NumWords-1:0][WordW-1:0] block_t;
  typedef logic [NumKeys-1:0][WordW-1:0]  key_t;
  typedef logic [RotW-1:0]                rot_t;

  typedef enum logic {
    CmdEncrypt = 1'b0,
    CmdDecrypt = 1'b1
  } cmd_e;

  // Left rotations of words 1..3 after forward rounds 0..2: RotTab[round][word-1].
  localparam rot_t RotTab [3][3] = '{
    '{rot_t'(1), rot_t'(2),  rot_t'(3)},
    '{rot_t'(4), rot_t'(8),  rot_t'(12)},
    '{rot_t'(8), rot_t'(12), rot_t'(16)}
  };

  function automatic word_t rotl(word_t w, rot_t n);
    return (w << n) | (w >> ((RotW+1)'(WordW) - {1'b0, n}));
  endfunction

  function automatic word_t rotr(word_t w, rot_t n);
    return (w >> n) | (w << ((RotW+1)'(WordW) - {1'b0, n}));
  endfunction

  function automatic byte_t fold_bytes(word_t w);
    return w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
  endfunction

  // Keep bits where the key is set, exchange the pair where it is clear.
  function automatic block_t cswap(block_t b, int unsigned x, int unsigned y, word_t k);
    word_t diff;
    block_t r;
    diff = (b[x] ^ b[y]) & ~k;
    r = b;
    r[x] = b[x] ^ diff;
    r[y] = b[y] ^ diff;
    return r;
  endfunction

  function automatic block_t mix_cols(block_t b, key_t k);
    block_t r;
    r = cswap(b, 0, 1, k[0]);
    r = cswap(r, 2, 3, k[1]);
    r = cswap(r, 2, 1, k[2]);
    r = cswap(r, 0, 3, k[3]);
    return r;
  endfunction

  function automatic block_t unmix_cols(block_t b, key_t k);
    block_t r;
    r = cswap(b, 0, 3, k[3]);
    r = cswap(r, 2, 1, k[2]);
    r = cswap(r, 2, 3, k[1]);
    r = cswap(r, 0, 1, k[0]);
    return r;
  endfunction

  function automatic block_t rot_fwd(block_t b, logic [1:0] rnd);
    block_t r;
    r = b;
    for (int w = 1; w < NumWords; w++) begin
      r[w] = rotl(b[w], RotTab[rnd][w-1]);
    end
    return r;
  endfunction

  function automatic block_t rot_inv(block_t b, logic [1:0] rnd);
    block_t r;
    r = b;
    for (int w = 1; w < NumWords; w++) begin
      r[w] = rotr(b[w], RotTab[rnd][w-1]);
    end
    return r;
  endfunction

  // Fold the data byte into the padding and place it in the low byte of word 3.
  function automatic block_t insert_byte(block_t b, byte_t d);
    block_t r;
    byte_t f;
    f = d ^ fold_bytes(b[0]) ^ fold_bytes(b[1]) ^ fold_bytes(b[2])
          ^ fold_bytes({b[3][WordW-1:ByteW], {ByteW{1'b0}}});
    r = b;
    r[3] = {b[3][WordW-1:ByteW], f};
    return r;
  endfunction

endpackage

FILE: hdl/keyed_bit_permutation_cipher_unit.sv
// Four round stages, one round each, from request acceptance to result valid.
// Throughput: one request per cycle while out_stall_i is low; the stages advance
// independently, so a bubble fills while the output register waits on out_stall_i.
// Reset: asynchronous, active low; clears stage valid bits and all key words to 0.
// Keyed bit permutation cipher top level; depends on kbpc_pkg.
module keyed_bit_permutation_cipher_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [kbpc_pkg::KeyIdxW-1:0] cfg_idx_i,
  input  logic [kbpc_pkg::WordW-1:0]   cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   cmd_i,
  input  logic [7:0]             plain_byte_i,
  input  logic [31:0]            in_word0_i,
  input  logic [31:0]            in_word1_i,
  input  logic [31:0]            in_word2_i,
  input  logic [31:0]            in_word3_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [31:0]            out_word0_o,
  output logic [31:0]            out_word1_o,
  output logic [31:0]            out_word2_o,
  output logic [31:0]            out_word3_o,
  output logic [7:0]             recovered_byte_o
);
  import kbpc_pkg::*;

  key_t   key_q;
  logic   [NumStages-1:0] valid_q;
  cmd_e   cmd_q [NumStages];
  block_t blk_q [NumStages];
  byte_t  rec_q;

  logic   [NumStages-1:0] adv;
  cmd_e   src_cmd [NumStages];
  block_t src_blk [NumStages];
  logic   [NumStages-1:0] src_valid;
  block_t nxt_blk [NumStages];
  byte_t  nxt_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    adv[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int s = NumStages-2; s >= 0; s--) begin
      adv[s] = !valid_q[s] || adv[s+1];
    end
  end

  assign in_stall_o = !adv[0];

  always_comb begin
    block_t t;
    src_valid[0] = in_valid_i;
    src_cmd[0]   = cmd_e'(cmd_i);
    src_blk[0]   = {in_word3_i, in_word2_i, in_word1_i, in_word0_i};
    for (int s = 1; s < NumStages; s++) begin
      src_valid[s] = valid_q[s-1];
      src_cmd[s]   = cmd_q[s-1];
      src_blk[s]   = blk_q[s-1];
    end
    nxt_rec = '0;
    for (int s = 0; s < NumStages; s++) begin
      if (src_cmd[s] == CmdDecrypt) begin
        t = unmix_cols(src_blk[s], key_q);
        if (s < NumStages-1) begin
          t = rot_inv(t, 2'(NumStages-2-s));
        end
      end else begin
        t = src_blk[s];
        if (s == 0) begin
          t = insert_byte(t, plain_byte_i);
        end
        t = mix_cols(t, key_q);
        if (s < NumStages-1) begin
          t = rot_fwd(t, 2'(s));
        end
      end
      nxt_blk[s] = t;
    end
    // Decrypt returns the XOR of all bytes of the recovered block; encrypt returns zero.
    if (src_cmd[NumStages-1] == CmdDecrypt) begin
      t = nxt_blk[NumStages-1];
      nxt_rec = fold_bytes(t[0]) ^ fold_bytes(t[1]) ^ fold_bytes(t[2]) ^ fold_bytes(t[3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NumStages; s++) begin
        if (adv[s]) begin
          valid_q[s] <= src_valid[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NumStages; s++) begin
      if (adv[s] && src_valid[s]) begin
        cmd_q[s] <= src_cmd[s];
        blk_q[s] <= nxt_blk[s];
      end
    end
    if (adv[NumStages-1] && src_valid[NumStages-1]) begin
      rec_q <= nxt_rec;
    end
  end

  assign out_valid_o      = valid_q[NumStages-1];
  assign out_word0_o      = blk_q[NumStages-1][0];
  assign out_word1_o      = blk_q[NumStages-1][1];
  assign out_word2_o      = blk_q[NumStages-1][2];
  assign out_word3_o      = blk_q[NumStages-1][3];
  assign recovered_byte_o = rec_q;

  a_enc_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cmd_q[NumStages-1] == CmdEncrypt) |-> (recovered_byte_o == '0))
    else $error("encrypt result carries a nonzero recovered byte");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while a stage is empty");

  a_accept_fills_stage0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted request lost at stage 0");

  a_held_stage_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[1] && !adv[1]) |=> (valid_q[1] && $stable(blk_q[1])))
    else $error("held stage 1 content changed");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for keyed_bit_permutation_cipher_unit: directed table, then random
// encrypt, decrypt and round-trip requests under several key settings, with stalls.
// Depends on kbpc_pkg for the block types and the command encoding.
module tb_top;
  import kbpc_pkg::*;

  typedef enum logic [KeyIdxW-1:0] {
    RegKeyWord0 = 0,
    RegKeyWord1 = 1,
    RegKeyWord2 = 2,
    RegKeyWord3 = 3
  } key_reg_e;

  typedef struct packed {
    cmd_e   cmd;
    byte_t  plain;
    block_t blk;
  } cipher_req_t;

  typedef struct packed {
    block_t blk;
    byte_t  rec;
  } cipher_res_t;

  typedef struct packed {
    logic        fixed;
    cipher_req_t req;
    cipher_res_t res;
  } directed_row_t;

  localparam int          CycleLimit  = 200000;
  localparam int          PhaseItems  = 118;
  localparam block_t      AllZero     = '0;
  localparam block_t      AllOne      = '1;
  localparam cipher_res_t NoAnswer    = '0;
  // Left rotations of words 1..3 after forward rounds 0..2.
  localparam int unsigned RotAmount [3][3] = '{'{1, 2, 3}, '{4, 8, 12}, '{8, 12, 16}};

  // Typed answers only where the block is invariant under any key and rotation.
  localparam directed_row_t DirectedRows [16] = '{
    '{1'b1, '{CmdEncrypt, 8'h00, AllZero}, '{AllZero, 8'h00}},
    '{1'b1, '{CmdEncrypt, 8'h00, AllOne},  '{AllOne, 8'h00}},
    '{1'b1, '{CmdDecrypt, 8'h00, AllZero}, '{AllZero, 8'h00}},
    '{1'b1, '{CmdDecrypt, 8'hFF, AllOne},  '{AllOne, 8'h00}},
    '{1'b0, '{CmdEncrypt, 8'hFF, AllOne},  NoAnswer},
    '{1'b0, '{CmdEncrypt, 8'hFF, AllZero}, NoAnswer},
    '{1'b0, '{CmdEncrypt, 8'h01, AllZero}, NoAnswer},
    '{1'b0, '{CmdEncrypt, 8'h80, AllZero}, NoAnswer},
    '{1'b0, '{CmdEncrypt, 8'h00, block_t'({32'h000000FF, 32'h0, 32'h0, 32'h0})}, NoAnswer},
    '{1'b0, '{CmdEncrypt, 8'hA5,
              block_t'({32'h76543210, 32'hFEDCBA98, 32'h89ABCDEF, 32'h01234567})}, NoAnswer},
    '{1'b0, '{CmdEncrypt, 8'h7E,
              block_t'({32'h000000FF, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF})}, NoAnswer},
    '{1'b0, '{CmdDecrypt, 8'h00, block_t'({32'h0, 32'h0, 32'h0, 32'h00000001})}, NoAnswer},
    '{1'b0, '{CmdDecrypt, 8'h00, block_t'({32'h80000000, 32'h0, 32'h0, 32'h0})}, NoAnswer},
    '{1'b0, '{CmdDecrypt, 8'h5A,
              block_t'({32'h0, 32'h00000100, 32'h00010000, 32'h0})}, NoAnswer},
    '{1'b0, '{CmdDecrypt, 8'h00,
              block_t'({32'hCCCCCCCC, 32'h33333333, 32'hF0F0F0F0, 32'h0F0F0F0F})}, NoAnswer},
    '{1'b0, '{CmdDecrypt, 8'h00,
              block_t'({32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0})}, NoAnswer}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [KeyIdxW-1:0] cfg_idx_i;
  logic [WordW-1:0]   cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        cmd_i;
  logic [7:0]  plain_byte_i;
  logic [31:0] in_word0_i, in_word1_i, in_word2_i, in_word3_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] out_word0_o, out_word1_o, out_word2_o, out_word3_o;
  logic [7:0]  recovered_byte_o;

  logic        fixed_answer_en;
  cipher_res_t fixed_answer;

  key_t        key_copy;
  cipher_res_t pending_results [$];
  block_t      sealed_blocks [$];
  bit          calm;
  int          hold_cycles;
  int          mismatch_count;
  int          cycle_count;
  int          encrypt_seen;
  int          decrypt_seen;
  int          key_settings;

  keyed_bit_permutation_cipher_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .plain_byte_i    (plain_byte_i),
    .in_word0_i      (in_word0_i),
    .in_word1_i      (in_word1_i),
    .in_word2_i      (in_word2_i),
    .in_word3_i      (in_word3_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_word0_o     (out_word0_o),
    .out_word1_o     (out_word1_o),
    .out_word2_o     (out_word2_o),
    .out_word3_o     (out_word3_o),
    .recovered_byte_o(recovered_byte_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic word_t rot_left(word_t w, int unsigned n);
    return (w << n) | (w >> (WordW - n));
  endfunction

  function automatic word_t rot_right(word_t w, int unsigned n);
    return (w >> n) | (w << (WordW - n));
  endfunction

  function automatic byte_t xor_bytes(word_t w);
    return w[31:24] ^ w[23:16] ^ w[15:8] ^ w[7:0];
  endfunction

  // Exchange words a and c at every bit where the key bit is clear.
  function automatic block_t exchange(block_t b, int a, int c, word_t keep);
    word_t d;
    d = (b[a] ^ b[c]) & ~keep;
    b[a] = b[a] ^ d;
    b[c] = b[c] ^ d;
    return b;
  endfunction

  function automatic block_t scramble_block(block_t b, bit inverse);
    if (!inverse) begin
      b = exchange(b, 0, 1, key_copy[0]);
      b = exchange(b, 2, 3, key_copy[1]);
      b = exchange(b, 2, 1, key_copy[2]);
      b = exchange(b, 0, 3, key_copy[3]);
    end else begin
      b = exchange(b, 0, 3, key_copy[3]);
      b = exchange(b, 2, 1, key_copy[2]);
      b = exchange(b, 2, 3, key_copy[1]);
      b = exchange(b, 0, 1, key_copy[0]);
    end
    return b;
  endfunction

  function automatic cipher_res_t predict_cipher(cipher_req_t req);
    block_t      b;
    cipher_res_t res;
    b = req.blk;
    res.rec = '0;
    if (req.cmd == CmdEncrypt) begin
      // Clear the low byte of word 3, then fold the data byte into it.
      b[3][7:0] = req.plain ^ xor_bytes(b[0]) ^ xor_bytes(b[1]) ^ xor_bytes(b[2])
                  ^ xor_bytes({b[3][31:8], 8'h00});
      for (int rnd = 0; rnd < 4; rnd++) begin
        b = scramble_block(b, 1'b0);
        if (rnd < 3) begin
          for (int w = 1; w < 4; w++) b[w] = rot_left(b[w], RotAmount[rnd][w-1]);
        end
      end
    end else begin
      for (int rnd = 3; rnd >= 0; rnd--) begin
        b = scramble_block(b, 1'b1);
        if (rnd > 0) begin
          for (int w = 1; w < 4; w++) b[w] = rot_right(b[w], RotAmount[rnd-1][w-1]);
        end
      end
      res.rec = xor_bytes(b[0]) ^ xor_bytes(b[1]) ^ xor_bytes(b[2]) ^ xor_bytes(b[3]);
    end
    res.blk = b;
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %h, got %h", name, expected, actual);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    cipher_req_t req;
    cipher_res_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        req = '{cmd_e'(cmd_i), plain_byte_i,
                {in_word3_i, in_word2_i, in_word1_i, in_word0_i}};
        pending_results.push_back(fixed_answer_en ? fixed_answer : predict_cipher(req));
        if (req.cmd == CmdEncrypt) encrypt_seen++;
        else decrypt_seen++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_word0", want.blk[0], out_word0_o);
          check_field("out_word1", want.blk[1], out_word1_o);
          check_field("out_word2", want.blk[2], out_word2_o);
          check_field("out_word3", want.blk[3], out_word3_o);
          check_field("recovered_byte", {24'h0, want.rec}, {24'h0, recovered_byte_o});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Hold the output side in short random bursts unless the run is calm.
  always @(negedge clk_i) begin
    if (calm) hold_cycles = 0;
    else if (hold_cycles == 0 && $urandom_range(0, 4) == 0) hold_cycles = $urandom_range(1, 3);
    out_stall_i <= (hold_cycles != 0);
    if (hold_cycles != 0) hold_cycles--;
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_request(cipher_req_t req, logic fixed, cipher_res_t answer);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    cmd_i           <= req.cmd;
    plain_byte_i    <= req.plain;
    in_word0_i      <= req.blk[0];
    in_word1_i      <= req.blk[1];
    in_word2_i      <= req.blk[2];
    in_word3_i      <= req.blk[3];
    fixed_answer_en <= fixed;
    fixed_answer    <= answer;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_key(key_reg_e idx, word_t value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    key_copy[idx] = value;
  endtask

  task automatic program_keys(word_t k0, word_t k1, word_t k2, word_t k3);
    write_key(RegKeyWord0, k0);
    write_key(RegKeyWord1, k1);
    write_key(RegKeyWord2, k2);
    write_key(RegKeyWord3, k3);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    // Old ciphertexts no longer round-trip under new keys.
    sealed_blocks.delete();
    key_settings++;
  endtask

  function automatic word_t random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random_phase(int count);
    cipher_req_t req;
    cipher_res_t sealed;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      req.plain = byte_t'($urandom_range(0, 255));
      req.blk   = {$urandom, $urandom, $urandom, $urandom};
      if (pick < 45) begin
        req.cmd = CmdEncrypt;
        sealed = predict_cipher(req);
        sealed_blocks.push_back(sealed.blk);
        if (sealed_blocks.size() > 16) void'(sealed_blocks.pop_front());
      end else if (pick < 80 && sealed_blocks.size() != 0) begin
        // Decrypt a block sealed under the current keys: the data byte comes back.
        req.cmd = CmdDecrypt;
        req.blk = sealed_blocks[$urandom_range(0, sealed_blocks.size() - 1)];
      end else begin
        req.cmd = cmd_e'($urandom_range(0, 1));
        req.blk = {random_word(), random_word(), random_word(), random_word()};
      end
      send_request(req, 1'b0, NoAnswer);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = RegKeyWord0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    cmd_i           = CmdEncrypt;
    plain_byte_i    = '0;
    in_word0_i      = '0;
    in_word1_i      = '0;
    in_word2_i      = '0;
    in_word3_i      = '0;
    fixed_answer_en = 1'b0;
    fixed_answer    = NoAnswer;
    key_copy        = '0;
    calm            = 1'b0;
    hold_cycles     = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    encrypt_seen    = 0;
    decrypt_seen    = 0;
    key_settings    = 1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows run under the reset keys, where every bit is swapped.
    foreach (DirectedRows[i]) begin
      send_request(DirectedRows[i].req, DirectedRows[i].fixed, DirectedRows[i].res);
    end
    drain_pipeline();

    program_keys('1, '1, '1, '1);
    run_random_phase(PhaseItems);
    drain_pipeline();
    program_keys('0, '0, '0, '0);
    run_random_phase(PhaseItems);
    drain_pipeline();
    program_keys(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555);
    run_random_phase(PhaseItems);
    drain_pipeline();
    program_keys(word_t'(1) << $urandom_range(0, 31), word_t'(1) << $urandom_range(0, 31),
                 word_t'(1) << $urandom_range(0, 31), word_t'(1) << $urandom_range(0, 31));
    run_random_phase(PhaseItems);
    drain_pipeline();
    program_keys($urandom, $urandom, $urandom, $urandom);
    run_random_phase(PhaseItems);
    drain_pipeline();
    calm = 1'b1;
    program_keys($urandom, $urandom, $urandom, $urandom);
    run_random_phase(PhaseItems);
    drain_pipeline();
    calm = 1'b0;
    program_keys($urandom, $urandom, $urandom, $urandom);
    run_random_phase(PhaseItems);
    drain_pipeline();
    // Close with back-to-back traffic and no stalls.
    calm = 1'b1;
    program_keys($urandom, $urandom, $urandom, $urandom);
    run_random_phase(PhaseItems);
    drain_pipeline();
    repeat (8) @(posedge clk_i);

    $display("Checked %0d encrypt and %0d decrypt requests under %0d key settings,",
             encrypt_seen, decrypt_seen, key_settings);
    $display("with random input gaps and output stalls in most phases.");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
